// File: hw/rtl/rkd_pkg.sv
// Shared types and constants for the RSA key derivation unit.
// No dependencies.
package rkd_pkg;

    // Width of every result word on the output channel.
    localparam int unsigned OUT_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_PHI,
        ST_DIV_GCD,
        ST_DIV_Q,
        ST_K_INIT,
        ST_K_STEP,
        ST_DONE
    } rkd_state_t;

endpackage

// File: hw/rtl/rsa_key_derivation_unit.sv
// Flow: when p or q is below 2, the two multiplies are followed directly by the output beat.
// Otherwise two multiplies (n, then phi), then the shared restoring divider runs every Euclid
// step of every candidate e plus one phi/e division, then the k search steps until s is zero.
// One key at a time: s_ready is high only while the sequencer is idle.
// Reset: synchronous, active-low aresetn clears the sequencer and the output valid.
// RSA key derivation top level: shared multiplier, shared divider, small sequencer.
// Depends on rkd_pkg.
module rsa_key_derivation_unit #(
    parameter int unsigned PRIME_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PRIME_WIDTH-1:0]            s_prime_p,
    input  logic [PRIME_WIDTH-1:0]            s_prime_q,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rkd_pkg::OUT_WIDTH-1:0]     m_modulus,
    output logic [rkd_pkg::OUT_WIDTH-1:0]     m_public_exponent,
    output logic [rkd_pkg::OUT_WIDTH-1:0]     m_private_exponent,
    output logic                              m_bad_input
);
    import rkd_pkg::*;

    localparam int unsigned DW = 2 * PRIME_WIDTH;
    localparam int unsigned SW = DW + 1;
    localparam int unsigned CW = $clog2(DW);
    localparam logic [DW-1:0] ONE_DW = DW'(1);
    localparam logic [DW-1:0] TWO_DW = DW'(2);
    localparam logic [CW-1:0] CNT_LOAD = CW'(DW - 1);

    rkd_state_t state_reg, state_next;

    logic [PRIME_WIDTH-1:0] p_reg, p_next;
    logic [PRIME_WIDTH-1:0] q_reg, q_next;
    logic                   bad_reg, bad_next;
    logic [DW-1:0]          n_reg, n_next;
    logic [DW-1:0]          phi_reg, phi_next;
    logic [DW-1:0]          e_reg, e_next;
    logic [DW-1:0]          div_num_reg, div_num_next;
    logic [DW-1:0]          div_rem_reg, div_rem_next;
    logic [DW-1:0]          div_den_reg, div_den_next;
    logic [CW-1:0]          div_cnt_reg, div_cnt_next;
    logic [DW-1:0]          rem_e_reg, rem_e_next;
    logic [DW-1:0]          s_reg, s_next;
    logic [OUT_WIDTH-1:0]   quo_reg, quo_next;
    logic [OUT_WIDTH-1:0]   d_reg, d_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_WIDTH-1:0]   m_modulus_reg, m_modulus_next;
    logic [OUT_WIDTH-1:0]   m_pub_reg, m_pub_next;
    logic [OUT_WIDTH-1:0]   m_priv_reg, m_priv_next;
    logic                   m_bad_reg, m_bad_next;

    // shared multiplier
    logic [PRIME_WIDTH-1:0] mul_a, mul_b;
    logic [DW-1:0]          mul_prod;

    // shared restoring divider, one quotient bit per cycle
    logic [SW-1:0] rem_shift;
    logic [SW-1:0] rem_sub;
    logic          rem_ge;
    logic [DW-1:0] div_q_new;
    logic [DW-1:0] div_r_new;

    // k search adder
    logic [SW-1:0] k_add_a, k_add_b, k_sum, k_sum_sub;
    logic          k_wrap;
    logic [DW-1:0] k_mod;

    logic [63:0]   n_wide, e_wide, q_wide;

    always_comb begin
        if (state_reg == ST_MUL_N) begin
            mul_a = p_reg;
            mul_b = q_reg;
        end else begin
            mul_a = p_reg - PRIME_WIDTH'(1);
            mul_b = q_reg - PRIME_WIDTH'(1);
        end
        mul_prod = DW'(mul_a) * DW'(mul_b);
    end

    always_comb begin
        rem_shift = {div_rem_reg, div_num_reg[DW-1]};
        rem_ge    = rem_shift >= {1'b0, div_den_reg};
        rem_sub   = rem_shift - {1'b0, div_den_reg};
        div_r_new = rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
        div_q_new = {div_num_reg[DW-2:0], rem_ge};
    end

    // s tracks (k*rem + 1) mod e; a wrap adds one to the quotient part of d
    always_comb begin
        if (state_reg == ST_K_INIT) begin
            k_add_a = {1'b0, rem_e_reg};
            k_add_b = SW'(1);
        end else begin
            k_add_a = {1'b0, s_reg};
            k_add_b = {1'b0, rem_e_reg};
        end
        k_sum     = k_add_a + k_add_b;
        k_wrap    = k_sum >= {1'b0, e_reg};
        k_sum_sub = k_sum - {1'b0, e_reg};
        k_mod     = k_wrap ? k_sum_sub[DW-1:0] : k_sum[DW-1:0];
    end

    assign n_wide = 64'(n_reg);
    assign e_wide = 64'(e_reg);
    assign q_wide = 64'(div_q_new);

    always_comb begin
        state_next     = state_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        bad_next       = bad_reg;
        n_next         = n_reg;
        phi_next       = phi_reg;
        e_next         = e_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        rem_e_next     = rem_e_reg;
        s_next         = s_reg;
        quo_next       = quo_reg;
        d_next         = d_reg;
        m_valid_next   = m_valid_reg;
        m_modulus_next = m_modulus_reg;
        m_pub_next     = m_pub_reg;
        m_priv_next    = m_priv_reg;
        m_bad_next     = m_bad_reg;
        s_ready        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    p_next     = s_prime_p;
                    q_next     = s_prime_q;
                    bad_next   = (s_prime_p < PRIME_WIDTH'(2)) ||
                                 (s_prime_q < PRIME_WIDTH'(2));
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                n_next     = mul_prod;
                state_next = ST_MUL_PHI;
            end
            ST_MUL_PHI: begin
                phi_next     = mul_prod;
                e_next       = TWO_DW;
                div_num_next = mul_prod;
                div_rem_next = '0;
                div_den_next = TWO_DW;
                div_cnt_next = CNT_LOAD;
                state_next   = bad_reg ? ST_DONE : ST_DIV_GCD;
            end
            ST_DIV_GCD: begin
                div_num_next = div_q_new;
                div_rem_next = div_r_new;
                div_cnt_next = div_cnt_reg - CW'(1);
                if (div_cnt_reg == '0) begin
                    div_rem_next = '0;
                    div_cnt_next = CNT_LOAD;
                    if (div_r_new != '0) begin
                        // next Euclid step: gcd(den, rem)
                        div_num_next = div_den_reg;
                        div_den_next = div_r_new;
                    end else if (div_den_reg == ONE_DW) begin
                        // coprime: divide phi by e for quotient and remainder
                        div_num_next = phi_reg;
                        div_den_next = e_reg;
                        state_next   = ST_DIV_Q;
                    end else begin
                        e_next       = e_reg + ONE_DW;
                        div_num_next = phi_reg;
                        div_den_next = e_reg + ONE_DW;
                    end
                end
            end
            ST_DIV_Q: begin
                div_num_next = div_q_new;
                div_rem_next = div_r_new;
                div_cnt_next = div_cnt_reg - CW'(1);
                if (div_cnt_reg == '0) begin
                    quo_next   = q_wide[OUT_WIDTH-1:0];
                    rem_e_next = div_r_new;
                    state_next = ST_K_INIT;
                end
            end
            ST_K_INIT: begin
                s_next     = k_mod;
                d_next     = quo_reg + (k_wrap ? 32'd1 : 32'd0);
                state_next = ST_K_STEP;
            end
            ST_K_STEP: begin
                if (s_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    s_next = k_mod;
                    d_next = d_reg + quo_reg + (k_wrap ? 32'd1 : 32'd0);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_modulus_next = n_wide[OUT_WIDTH-1:0];
                    m_pub_next     = bad_reg ? '0 : e_wide[OUT_WIDTH-1:0];
                    m_priv_next    = bad_reg ? '0 : d_reg;
                    m_bad_next     = bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg         <= p_next;
        q_reg         <= q_next;
        bad_reg       <= bad_next;
        n_reg         <= n_next;
        phi_reg       <= phi_next;
        e_reg         <= e_next;
        div_num_reg   <= div_num_next;
        div_rem_reg   <= div_rem_next;
        div_den_reg   <= div_den_next;
        div_cnt_reg   <= div_cnt_next;
        rem_e_reg     <= rem_e_next;
        s_reg         <= s_next;
        quo_reg       <= quo_next;
        d_reg         <= d_next;
        m_modulus_reg <= m_modulus_next;
        m_pub_reg     <= m_pub_next;
        m_priv_reg    <= m_priv_next;
        m_bad_reg     <= m_bad_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_modulus          = m_modulus_reg;
    assign m_public_exponent  = m_pub_reg;
    assign m_private_exponent = m_priv_reg;
    assign m_bad_input        = m_bad_reg;

endmodule

// File: hw/rtl/rkd_checker.sv
// Port-level checks for rsa_key_derivation_unit, bound to the top level.
// Depends on rkd_pkg and the top level's port names.
module rkd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rkd_pkg::OUT_WIDTH-1:0] m_modulus,
    input logic [rkd_pkg::OUT_WIDTH-1:0] m_public_exponent,
    input logic [rkd_pkg::OUT_WIDTH-1:0] m_private_exponent,
    input logic                          m_bad_input
);
    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_modulus) &&
        $stable(m_public_exponent) && $stable(m_private_exponent) && $stable(m_bad_input))
        else $error("result beat changed while stalled");

    // one key at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a key is in progress");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_input |-> m_public_exponent == '0 && m_private_exponent == '0)
        else $error("exponents nonzero on bad input");

    a_e_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_input |-> m_public_exponent >= 32'd2 &&
        m_private_exponent != '0)
        else $error("public exponent below 2 or private exponent zero");

endmodule

bind rsa_key_derivation_unit rkd_checker u_rkd_checker (.*);
